[hw/rtl/depth_pixel_backprojection_assert.svh]
// Assertion macros for the back-projection RTL.
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DPB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, checked outside reset.
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

[hw/rtl/dpb_pkg.sv]
// Types and constants of the depth pixel back-projection pipeline.
package dpb_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEPTH_W    = 16;
    localparam int CENTER_W   = 16;
    localparam int INV_W      = 24;
    localparam int Z_W        = 31;
    localparam int COORD_W    = 32;
    localparam int COLOR_W    = 8;

    // Pipeline depth: stage 0 captures the pixel, the last stage is the output register.
    localparam int NUM_STAGES = 6;

    // Lateral datapath widths.
    localparam int OFF_W    = COORD_BITS + 4;
    localparam int MAG_W    = (OFF_W > CENTER_W) ? OFF_W : CENTER_W;
    localparam int M_W      = MAG_W + Z_W;
    localparam int LO_W     = M_W / 2;
    localparam int HI_W     = M_W - LO_W;
    localparam int PL_W     = LO_W + INV_W;
    localparam int PH_W     = HI_W + INV_W;
    localparam int S_W      = M_W + INV_W;
    localparam int FRAC_DROP = 28;
    localparam int Q_W      = S_W - FRAC_DROP;

    localparam logic [COORD_W-1:0] Q_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] Q_MAX_NEG = 32'h8000_0000;

    // Register reset values.
    localparam logic [INV_W-1:0]    RST_INV_DEPTH_SCALE = 24'd16777;
    localparam logic [CENTER_W-1:0] RST_CENTER_X        = 16'd5120;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y        = 16'd3840;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X     = 24'd31957;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y     = 24'd31957;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_DEPTH_SCALE = 3'd0,
        CFG_CENTER_X        = 3'd1,
        CFG_CENTER_Y        = 3'd2,
        CFG_INV_FOCAL_X     = 3'd3,
        CFG_INV_FOCAL_Y     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_W-1:0]    depth_raw;
        logic [COLOR_W-1:0]    blue_in;
        logic [COLOR_W-1:0]    green_in;
        logic [COLOR_W-1:0]    red_in;
    } t_pixel;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [Z_W-1:0]            point_z;
        logic [COLOR_W-1:0]        blue_out;
        logic [COLOR_W-1:0]        green_out;
        logic [COLOR_W-1:0]        red_out;
    } t_point;

    // Per-stage load enables handed to the datapath units.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

[hw/rtl/depth_pixel_backprojection.sv]
// Top level of the pinhole depth back-projection pipeline.
//
// Usage: pixels enter on the input channel (i_in_valid / o_in_ready, payload
// i_pixel) and colored 3D points leave on the output channel (o_out_valid /
// i_out_ready, payload o_point). A pixel yields a point only when its depth
// is nonzero and both its column and row are even; any other item is taken
// and dropped without a result.
// An item that is accepted passes through six register stages, from stage 0
// to the output register, before it shows on o_out_valid. Throughput is one
// item per cycle while i_out_ready holds. The longest path per stage is one
// multiplier of at most 32 by 32 bits or one 71-bit add; the lateral product
// is split into two partial products so that each stage stays that short.
// Configuration is written through i_cfg_valid / o_cfg_ready with a register
// index and data; it is always ready and should be written only while the
// pipeline is empty.
// Reset (synchronous, active low) empties the pipeline and loads the default
// camera intrinsics. When the receiver stalls, each stage holds its item and
// bubbles ahead of the stall still close up, so the input keeps accepting
// items until every stage is full; nothing is lost or repeated.
`include "depth_pixel_backprojection_assert.svh"

module depth_pixel_backprojection
    import dpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pixel                i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_point                o_point,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Camera registers.
    logic [INV_W-1:0]    r_inv_depth_scale;
    logic [CENTER_W-1:0] r_center_x;
    logic [CENTER_W-1:0] r_center_y;
    logic [INV_W-1:0]    r_inv_focal_x;
    logic [INV_W-1:0]    r_inv_focal_y;

    // Writes are applied in the cycle they are offered; the port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_depth_scale <= RST_INV_DEPTH_SCALE;
            r_center_x        <= RST_CENTER_X;
            r_center_y        <= RST_CENTER_Y;
            r_inv_focal_x     <= RST_INV_FOCAL_X;
            r_inv_focal_y     <= RST_INV_FOCAL_Y;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INV_DEPTH_SCALE: r_inv_depth_scale <= i_cfg_data;
                CFG_CENTER_X:        r_center_x        <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:        r_center_y        <= i_cfg_data[CENTER_W-1:0];
                CFG_INV_FOCAL_X:     r_inv_focal_x     <= i_cfg_data;
                CFG_INV_FOCAL_Y:     r_inv_focal_y     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline control. A stage may load when it is empty or when the stage
    // after it loads in the same cycle, so bubbles are squeezed out under a
    // stall. Items that produce no point enter as bubbles.
    logic [NUM_STAGES-1:0] r_vld;
    t_pipe_ctl             ctl;
    logic                  keep;

    always_comb begin
        ctl.en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ctl.en[k] = !r_vld[k] || ctl.en[k+1];
        end
    end

    assign o_in_ready = ctl.en[0];
    assign keep = (i_pixel.depth_raw != '0) && !i_pixel.column[0] && !i_pixel.row[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ctl.en[0]) begin
                r_vld[0] <= i_in_valid && keep;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ctl.en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // The color bytes ride alongside the arithmetic.
    logic [3*COLOR_W-1:0] r_rgb [NUM_STAGES];

    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_rgb[0] <= {i_pixel.blue_in, i_pixel.green_in, i_pixel.red_in};
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ctl.en[k]) begin
                r_rgb[k] <= r_rgb[k-1];
            end
        end
    end

    // Datapath units.
    logic [Z_W-1:0]            z_early;
    logic [Z_W-1:0]            z_out;
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;

    dpb_depth u_depth (
        .i_clk             (i_clk),
        .i_ctl             (ctl),
        .i_depth_raw       (i_pixel.depth_raw),
        .i_inv_depth_scale (r_inv_depth_scale),
        .o_z_early         (z_early),
        .o_z               (z_out)
    );

    dpb_lateral u_lat_x (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_pix       (i_pixel.column),
        .i_center    (r_center_x),
        .i_inv_focal (r_inv_focal_x),
        .i_z         (z_early),
        .o_coord     (x_out)
    );

    dpb_lateral u_lat_y (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_pix       (i_pixel.row),
        .i_center    (r_center_y),
        .i_inv_focal (r_inv_focal_y),
        .i_z         (z_early),
        .o_coord     (y_out)
    );

    assign o_out_valid       = r_vld[NUM_STAGES-1];
    assign o_point.point_x   = x_out;
    assign o_point.point_y   = y_out;
    assign o_point.point_z   = z_out;
    assign o_point.blue_out  = r_rgb[NUM_STAGES-1][3*COLOR_W-1:2*COLOR_W];
    assign o_point.green_out = r_rgb[NUM_STAGES-1][2*COLOR_W-1:COLOR_W];
    assign o_point.red_out   = r_rgb[NUM_STAGES-1][COLOR_W-1:0];

    // An accepted pixel with an odd column never enters the pipeline.
    `DPB_ASSERT_NEXT(a_odd_column_dropped, i_clk, i_rst_n,
        i_in_valid && o_in_ready && i_pixel.column[0], !r_vld[0])

    // The input is held off only when every stage holds an item.
    `DPB_ASSERT_NOW(a_ready_only_when_full, i_clk, i_rst_n, !o_in_ready, &r_vld)

    // A stalled point stays in the output register.
    `DPB_ASSERT_NEXT(a_output_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A point at zero depth lies on the optical center.
    `DPB_ASSERT_NOW(a_zero_depth_origin, i_clk, i_rst_n,
        o_out_valid && (o_point.point_z == '0),
        (o_point.point_x == '0) && (o_point.point_y == '0))

endmodule

[hw/rtl/dpb_depth.sv]
// Depth scaling unit: raw depth times the inverse scale, floored and saturated to Q15.16.
module dpb_depth
    import dpb_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  logic [DEPTH_W-1:0] i_depth_raw,
    input  logic [INV_W-1:0]   i_inv_depth_scale,
    output logic [Z_W-1:0]     o_z_early,
    output logic [Z_W-1:0]     o_z
);

    localparam int ZP_W = DEPTH_W + INV_W;

    logic [ZP_W-1:0] r_zprod;
    logic [ZP_W-1:0] n_zprod;
    logic [Z_W-1:0]  r_zd [1:NUM_STAGES-1];
    logic [Z_W-1:0]  n_z;
    logic [Z_W:0]    zshift;

    assign n_zprod = ZP_W'(i_depth_raw) * ZP_W'(i_inv_depth_scale);
    assign zshift  = r_zprod[ZP_W-1:8];
    assign n_z     = zshift[Z_W] ? Q_MAX_POS[Z_W-1:0] : zshift[Z_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_zprod <= n_zprod;
        end
        if (i_ctl.en[1]) begin
            r_zd[1] <= n_z;
        end
        for (int k = 2; k < NUM_STAGES; k++) begin
            if (i_ctl.en[k]) begin
                r_zd[k] <= r_zd[k-1];
            end
        end
    end

    assign o_z_early = r_zd[1];
    assign o_z       = r_zd[NUM_STAGES-1];

endmodule

[hw/rtl/dpb_lateral.sv]
// One lateral axis: offset from the principal point, times z, times the inverse focal length.
module dpb_lateral
    import dpb_pkg::*;
(
    input  logic                      i_clk,
    input  t_pipe_ctl                 i_ctl,
    input  logic [COORD_BITS-1:0]     i_pix,
    input  logic [CENTER_W-1:0]       i_center,
    input  logic [INV_W-1:0]          i_inv_focal,
    input  logic [Z_W-1:0]            i_z,
    output logic signed [COORD_W-1:0] o_coord
);

    logic [MAG_W:0]     pix_ext;
    logic [MAG_W:0]     cen_ext;
    logic [MAG_W:0]     diff;
    logic [MAG_W:0]     diff_neg;

    logic               r_neg0, r_neg1, r_neg2, r_neg3, r_neg4;
    logic [MAG_W-1:0]   r_mag0, r_mag1;
    logic [M_W-1:0]     r_m;
    logic [M_W-1:0]     n_m;
    logic [PL_W-1:0]    r_pp_lo, n_pp_lo;
    logic [PH_W-1:0]    r_pp_hi, n_pp_hi;
    logic [S_W-1:0]     n_sum;
    logic [Q_W-1:0]     r_q;
    logic               r_rem;
    logic [Q_W:0]       q_up;
    logic [COORD_W-1:0] r_coord, n_coord;

    assign pix_ext  = (MAG_W+1)'({i_pix, 4'b0000});
    assign cen_ext  = (MAG_W+1)'(i_center);
    assign diff     = pix_ext - cen_ext;
    assign diff_neg = (MAG_W+1)'(0) - diff;

    assign n_m     = M_W'(r_mag1) * M_W'(i_z);
    assign n_pp_lo = PL_W'(r_m[LO_W-1:0]) * PL_W'(i_inv_focal);
    assign n_pp_hi = PH_W'(r_m[M_W-1:LO_W]) * PH_W'(i_inv_focal);
    assign n_sum   = (S_W'(r_pp_hi) << LO_W) + S_W'(r_pp_lo);

    // Negative results round the magnitude up so the signed value floors.
    assign q_up = (Q_W+1)'(r_q) + (Q_W+1)'(r_rem);

    always_comb begin
        if (!r_neg4) begin
            n_coord = (r_q > Q_W'(Q_MAX_POS)) ? Q_MAX_POS : r_q[COORD_W-1:0];
        end else if (q_up > (Q_W+1)'(Q_MAX_NEG)) begin
            n_coord = Q_MAX_NEG;
        end else begin
            n_coord = COORD_W'(0) - q_up[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_neg0 <= diff[MAG_W];
            r_mag0 <= diff[MAG_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
        end
        if (i_ctl.en[1]) begin
            r_neg1 <= r_neg0;
            r_mag1 <= r_mag0;
        end
        if (i_ctl.en[2]) begin
            r_neg2 <= r_neg1;
            r_m    <= n_m;
        end
        if (i_ctl.en[3]) begin
            r_neg3  <= r_neg2;
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
        end
        if (i_ctl.en[4]) begin
            r_neg4 <= r_neg3;
            r_q    <= n_sum[S_W-1:FRAC_DROP];
            r_rem  <= |n_sum[FRAC_DROP-1:0];
        end
        if (i_ctl.en[5]) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

[sim/depth_pixel_backprojection_tb.sv]
// Self-checking testbench for the depth pixel back-projection pipeline.
module depth_pixel_backprojection_tb;
    import dpb_pkg::*;

    // Run limits. The watchdog leaves ample margin over the slowest correct run.
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = NUM_STAGES + 6;
    localparam int CFG_NUM_REGS  = 5;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_POINTS  = 125;

    localparam logic signed [79:0] LATERAL_MAX = 80'sh7FFF_FFFF;
    localparam logic signed [79:0] LATERAL_MIN = -80'sh8000_0000;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // Block inputs, all known from time zero.
    logic                  in_valid  = 1'b0;
    t_pixel                pixel     = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic   o_in_ready;
    logic   o_out_valid;
    t_point o_point;
    logic   o_cfg_ready;

    // Camera intrinsics as the testbench believes the block holds them.
    logic [INV_W-1:0]    cam_inv_scale = RST_INV_DEPTH_SCALE;
    logic [CENTER_W-1:0] cam_center_x  = RST_CENTER_X;
    logic [CENTER_W-1:0] cam_center_y  = RST_CENTER_Y;
    logic [INV_W-1:0]    cam_inv_fx    = RST_INV_FOCAL_X;
    logic [INV_W-1:0]    cam_inv_fy    = RST_INV_FOCAL_Y;

    t_pixel     pixel_backlog[$];
    cfg_write_t cfg_backlog[$];
    t_point     pending_points[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int src_gap        = 0;
    int sink_stall     = 0;
    bit src_idle_on    = 1'b1;
    bit sink_idle_on   = 1'b1;

    depth_pixel_backprojection u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_point     (o_point),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Clock, plus a single reset pulse at the start of the run.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
    end

    // One lateral coordinate: the offset from the principal point (Q.4) times
    // z (Q.16) times the reciprocal focal length (Q0.24) is exact in 80 bits.
    // An arithmetic shift by 28 floors it to Q15.16, then it saturates.
    function automatic logic [COORD_W-1:0] lateral_coord(
        input logic [COORD_BITS-1:0] pix,
        input logic [CENTER_W-1:0]   center,
        input logic [Z_W-1:0]        z,
        input logic [INV_W-1:0]      inv
    );
        logic signed [17:0] offset;
        logic signed [79:0] product;
        logic signed [79:0] floored;
        offset  = $signed({2'b00, pix, 4'b0000}) - $signed({2'b00, center});
        product = offset * $signed({1'b0, z}) * $signed({1'b0, inv});
        floored = product >>> 28;
        if (floored > LATERAL_MAX)
            return Q_MAX_POS;
        if (floored < LATERAL_MIN)
            return Q_MAX_NEG;
        return floored[COORD_W-1:0];
    endfunction

    function automatic bit yields_point(input t_pixel px);
        return px.depth_raw != '0 && !px.column[0] && !px.row[0];
    endfunction

    // Expected point for a pixel under the current intrinsics.
    function automatic t_point project_pixel(input t_pixel px);
        logic [39:0]    z_product;
        logic [Z_W-1:0] z;
        t_point         pt;
        z_product = {24'b0, px.depth_raw} * {16'b0, cam_inv_scale};
        // z saturates to the largest positive Q15.16 value before it is reused.
        if (z_product[39:8] > {1'b0, Q_MAX_POS[Z_W-1:0]})
            z = Q_MAX_POS[Z_W-1:0];
        else
            z = z_product[Z_W+7:8];
        pt.point_x   = lateral_coord(px.column, cam_center_x, z, cam_inv_fx);
        pt.point_y   = lateral_coord(px.row, cam_center_y, z, cam_inv_fy);
        pt.point_z   = z;
        pt.blue_out  = px.blue_in;
        pt.green_out = px.green_in;
        pt.red_out   = px.red_in;
        return pt;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Pixel driver. An item is predicted at the edge where it is accepted, and
    // a new one is presented only once the current one is gone, so valid and
    // the payload hold steady while the block stalls.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready && yields_point(pixel))
                pending_points.insert(pending_points.size(), project_pixel(pixel));
            if (!in_valid || o_in_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_valid <= 1'b0;
                end else if (pixel_backlog.size() != 0) begin
                    in_valid <= 1'b1;
                    pixel    <= pixel_backlog.pop_front();
                    if (src_idle_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 3);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Point monitor. Ready drops in short random bursts to back-pressure the
    // pipeline; every accepted point is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_point want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pending_points.size() == 0) begin
                    $error("point received with none outstanding: %h", o_point);
                    mismatch_count++;
                end else begin
                    want = pending_points.pop_front();
                    check_field("point_x", want.point_x, o_point.point_x);
                    check_field("point_y", want.point_y, o_point.point_y);
                    check_field("point_z", {1'b0, want.point_z}, {1'b0, o_point.point_z});
                    check_field("blue_out", 32'(want.blue_out), 32'(o_point.blue_out));
                    check_field("green_out", 32'(want.green_out), 32'(o_point.green_out));
                    check_field("red_out", 32'(want.red_out), 32'(o_point.red_out));
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                out_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Register write driver. The local copy of the intrinsics follows each
    // accepted write, masked to the register width; unused indexes change nothing.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(cfg_index))
                    CFG_INV_DEPTH_SCALE: cam_inv_scale <= cfg_data[INV_W-1:0];
                    CFG_CENTER_X:        cam_center_x  <= cfg_data[CENTER_W-1:0];
                    CFG_CENTER_Y:        cam_center_y  <= cfg_data[CENTER_W-1:0];
                    CFG_INV_FOCAL_X:     cam_inv_fx    <= cfg_data[INV_W-1:0];
                    CFG_INV_FOCAL_Y:     cam_inv_fy    <= cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end
            if (!cfg_valid || o_cfg_ready) begin
                if (cfg_backlog.size() != 0) begin
                    cfg_valid <= 1'b1;
                    {cfg_index, cfg_data} <= cfg_backlog.pop_front();
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_pixel(input int col, input int row, input int depth,
                              input int b, input int g, input int r);
        t_pixel px;
        px.column    = col[COORD_BITS-1:0];
        px.row       = row[COORD_BITS-1:0];
        px.depth_raw = depth[DEPTH_W-1:0];
        px.blue_in   = b[COLOR_W-1:0];
        px.green_in  = g[COLOR_W-1:0];
        px.red_in    = r[COLOR_W-1:0];
        pixel_backlog.insert(pixel_backlog.size(), px);
    endtask

    // Waits until the pipeline is empty: all pixels taken, all points back,
    // and enough cycles for dropped pixels still in flight to leave.
    task automatic settle();
        while (pixel_backlog.size() != 0 || in_valid || pending_points.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Loads all five intrinsics plus one write to an unused index. Center
    // writes carry junk in the upper data bits, which the block must mask.
    task automatic program_camera(input logic [INV_W-1:0] inv_scale,
                                  input logic [CENTER_W-1:0] cx,
                                  input logic [CENTER_W-1:0] cy,
                                  input logic [INV_W-1:0] inv_fx,
                                  input logic [INV_W-1:0] inv_fy);
        logic [7:0] junk;
        junk = $urandom;
        cfg_backlog.insert(cfg_backlog.size(), {CFG_INV_DEPTH_SCALE, inv_scale});
        cfg_backlog.insert(cfg_backlog.size(), {CFG_CENTER_X, junk, cx});
        cfg_backlog.insert(cfg_backlog.size(), {CFG_CENTER_Y, ~junk, cy});
        cfg_backlog.insert(cfg_backlog.size(), {CFG_INV_FOCAL_X, inv_fx});
        cfg_backlog.insert(cfg_backlog.size(), {CFG_INV_FOCAL_Y, inv_fy});
        cfg_backlog.insert(cfg_backlog.size(),
                           {CFG_IDX_W'($urandom_range(CFG_NUM_REGS, 7)),
                            CFG_DATA_W'($urandom)});
        while (cfg_backlog.size() != 0 || cfg_valid)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Corners of the image, the principal point, odd coordinates, zero depth
    // and full-scale depth, with colors that toggle every bit.
    task automatic queue_directed();
        push_pixel(0, 0, 65535, 8'h00, 8'h00, 8'h00);
        push_pixel(4094, 4094, 65535, 8'hFF, 8'hFF, 8'hFF);
        push_pixel(0, 4094, 1, 8'h55, 8'hAA, 8'h0F);
        push_pixel(4094, 0, 1, 8'hAA, 8'h55, 8'hF0);
        push_pixel(320, 240, 1000, 8'h12, 8'h34, 8'h56);
        push_pixel(1, 0, 500, 8'h01, 8'h02, 8'h03);
        push_pixel(0, 1, 500, 8'h04, 8'h05, 8'h06);
        push_pixel(4095, 4095, 65535, 8'hFF, 8'h00, 8'hFF);
        push_pixel(2, 2, 0, 8'h0A, 8'h0B, 8'h0C);
        push_pixel(0, 0, 0, 8'h80, 8'h40, 8'h20);
        push_pixel(100, 200, 32768, 8'h7F, 8'h80, 8'h81);
        push_pixel(2048, 2048, 65535, 8'hC3, 8'h3C, 8'h99);
        push_pixel(4094, 4094, 32767, 8'h66, 8'h77, 8'h88);
        push_pixel(1024, 10, 3, 8'h11, 8'h22, 8'h33);
        push_pixel(10, 1024, 40000, 8'h44, 8'h55, 8'h66);
        push_pixel(638, 478, 4500, 8'hDE, 8'hAD, 8'hBE);
        push_pixel(4093, 2, 1200, 8'h01, 8'hFE, 8'h7E);
        push_pixel(2, 4093, 1200, 8'hFE, 8'h01, 8'h81);
    endtask

    // Mostly even pixels with real depth so that the datapath is exercised,
    // mixed with unconstrained pixels that the block has to drop.
    task automatic queue_random(input int points);
        int     made;
        t_pixel px;
        made = 0;
        while (made < points) begin
            px = t_pixel'({$urandom, $urandom});
            if ($urandom_range(0, 3) != 0) begin
                px.column[0] = 1'b0;
                px.row[0]    = 1'b0;
                case ($urandom_range(0, 5))
                    0:       px.depth_raw = 16'hFFFF;
                    1:       px.depth_raw = 16'(1 + $urandom_range(0, 15));
                    2:       px.depth_raw = 16'($urandom_range(300, 10000));
                    default: px.depth_raw = 16'($urandom_range(1, 65535));
                endcase
            end else if ($urandom_range(0, 2) == 0) begin
                px.depth_raw = '0;
            end
            if (yields_point(px))
                made++;
            pixel_backlog.insert(pixel_backlog.size(), px);
        end
    endtask

    // Test sequence: reset intrinsics, then extreme settings, then a run of
    // random settings. Each setting is loaded only with the pipeline empty.
    initial begin
        wait (rst_n);
        @(negedge i_clk);

        // Reset values of the intrinsics.
        queue_directed();
        settle();

        // Everything at full scale: lateral offsets are all negative, and at large
        // depths z saturates and x and y saturate low.
        program_camera('1, '1, '1, '1, '1);
        queue_directed();
        settle();

        // Principal point at the origin: offsets are never negative, and large ones saturate high at large depths.
        program_camera('1, '0, '0, '1, '1);
        queue_directed();
        settle();

        // All registers zero: every point collapses onto the origin.
        program_camera('0, '0, '0, '0, '0);
        queue_directed();
        settle();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            // Some phases run one side without gaps; the last runs both flat out.
            src_idle_on  = (phase != RAND_PHASES - 1) && (phase != 3);
            sink_idle_on = (phase != RAND_PHASES - 1) && (phase != 5);
            if (phase % 2 == 0)
                program_camera(INV_W'($urandom_range(1000, 70000)),
                               CENTER_W'($urandom_range(0, 65535)),
                               CENTER_W'($urandom_range(0, 65535)),
                               INV_W'($urandom_range(5000, 200000)),
                               INV_W'($urandom_range(5000, 200000)));
            else
                program_camera(INV_W'($urandom), CENTER_W'($urandom),
                               CENTER_W'($urandom), INV_W'($urandom),
                               INV_W'($urandom));
            queue_random(PHASE_POINTS);
            settle();
        end

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[depth_pixel_backprojection.f]
+incdir+hw/rtl
hw/rtl/dpb_pkg.sv
hw/rtl/dpb_depth.sv
hw/rtl/dpb_lateral.sv
hw/rtl/depth_pixel_backprojection.sv
sim/depth_pixel_backprojection_tb.sv
